// ===== rtl/core/ecbj_pkg.sv =====
// Shared types, constants and helpers for the encoder/button/joystick conditioner.
// No dependencies.
package ecbj_pkg;

    // Block parameters (defaults)
    localparam int OFF_CENTRE_LIMIT_DEF = 800;
    localparam int LONG_PRESS_MS_DEF    = 3000;

    // Fixed constants
    localparam logic [19:0] HELD_MAX    = 20'd1048575;
    localparam logic [20:0] TAP_MIN_MS  = 21'd40;
    localparam logic [20:0] HOLD_MIN_MS = 21'd500;
    localparam logic [15:0] DEAD_Q      = 16'd3932;
    localparam logic [15:0] HALF_Q      = 16'd16384;
    localparam logic [15:0] FLICK_Q     = 16'd22937;
    localparam logic [15:0] REARM_Q     = 16'd9831;
    localparam logic [15:0] ALPHA_Q     = 16'd9830;
    localparam logic [9:0]  OFF_CNT_MAX = 10'd1023;

    // Reciprocals: floor(us / 1000) = ((us >> 3) * MS_RECIP) >> 34 for us < 2^30,
    // floor(live * 32768 / 28836) = (live * LIVE_RECIP) >> 28 for live <= 28836
    localparam logic [27:0] MS_RECIP    = 28'd137438954;
    localparam logic [28:0] LIVE_RECIP  = 29'd305038599;

    // Configuration register indexes
    localparam logic [1:0] REG_ENC_STEPS = 2'd0;
    localparam logic [1:0] REG_CENTRE_X  = 2'd1;
    localparam logic [1:0] REG_CENTRE_Y  = 2'd2;
    localparam logic [1:0] REG_JOY_EN    = 2'd3;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE, S_ENC, S_MS, S_AX, S_LX, S_AY, S_LY, S_SMX, S_SMY, S_FIN
    } seq_state_t;

    // Divider request
    typedef struct packed {
        logic        start;
        logic [5:0]  nbits;
        logic [15:0] den;
        logic [47:0] num;   // left aligned, nbits used from the top
    } div_req_t;

    // Divider response
    typedef struct packed {
        logic        done;
        logic [47:0] quot;
        logic [16:0] rem;
    } div_rsp_t;

    // Centred axis prep
    typedef struct packed {
        logic [11:0] mag;
        logic [11:0] span;
        logic        neg;
    } axis_prep_t;

    function automatic axis_prep_t axis_prep(input logic [11:0] raw, input logic [11:0] centre);
        axis_prep_t p;
        p.neg  = raw < centre;
        p.mag  = (raw > centre) ? (raw - centre) : (centre - raw);
        p.span = (raw > centre) ? (12'd4095 - centre) : centre;
        return p;
    endfunction

endpackage

// ===== rtl/core/ecbj_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on ecbj_pkg.
module ecbj_div
    import ecbj_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [47:0] num_reg;
    logic [47:0] quot_reg;
    logic [16:0] rem_reg;
    logic [15:0] den_reg;
    logic [16:0] trial;
    logic        ge;

    // Trial subtract
    assign trial = {rem_reg[15:0], num_reg[47]};
    assign ge    = trial >= {1'b0, den_reg};

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= req.nbits;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 6'd1;
            else
                busy_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg  <= req.num;
            den_reg  <= req.den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            rem_reg  <= ge ? (trial - {1'b0, den_reg}) : trial;
            quot_reg <= {quot_reg[46:0], ge};
            num_reg  <= {num_reg[46:0], 1'b0};
        end
    end

    assign rsp.done = busy_reg && (cnt_reg == '0);
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== rtl/core/encoder_button_joystick_conditioner_top.sv =====
// Encoder/button/joystick conditioner: sequencer and datapath around one shared divider.
// Step divide (17 bits) on every poll, then two 27-bit axis divides with the stick on, all
// on the shared bit-serial divider.
// Throughput: one poll at a time, taken again once the result is loaded and the sequencer
// is back in idle, later under output stall. Async active-low reset clears the sequencer,
// persistent state and out_valid, and loads defaults (steps 4, centres 2048, joystick off).
module encoder_button_joystick_conditioner_top
    import ecbj_pkg::*;
#(
    parameter int OFF_CENTRE_LIMIT = OFF_CENTRE_LIMIT_DEF,
    parameter int LONG_PRESS_MS    = LONG_PRESS_MS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] encoder_delta_in,
    input  logic               boot_button,
    input  logic               encoder_button,
    input  logic               stick_button,
    input  logic [11:0]        raw_x,
    input  logic [11:0]        raw_y,
    input  logic [47:0]        time_us,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] detent_steps,
    output logic               button_down,
    output logic [19:0]        held_ms,
    output logic               tap,
    output logic               hold_release,
    output logic               long_press,
    output logic               press_from_boot,
    output logic               stick_click,
    output logic               stick_present,
    output logic signed [15:0] stick_x,
    output logic signed [15:0] stick_y,
    output logic [3:0]         flicks
);

    localparam logic [9:0]  OFF_LIMIT = 10'(OFF_CENTRE_LIMIT);
    localparam logic [19:0] LONG_MS   = 20'(LONG_PRESS_MS);

    seq_state_t state_reg, state_next;
    div_req_t   dreq;
    div_rsp_t   drsp;

    // Registers and persistent state
    logic [6:0]        enc_steps_reg;
    logic [11:0]       cx_reg, cy_reg;
    logic signed [7:0] enc_rem_reg;
    logic              btn_was_reg, long_done_reg, boot_origin_reg, stick_was_reg;
    logic              active_reg;
    logic [47:0]       press_start_reg;
    logic [9:0]        off_cnt_reg;
    logic signed [15:0] sx_reg, sy_reg;
    logic [1:0]        flick_rdy_reg;

    // Per-poll working registers
    logic              acc_neg_reg, pressed_reg, prev_down_reg, click_reg, present_reg;
    logic [47:0]       elapsed_reg;
    logic [11:0]       rawx_reg, rawy_reg;
    logic              dead_reg;
    logic [14:0]       live_reg;
    logic signed [15:0] ax_reg, ay_reg, q_reg;
    logic [19:0]       held_reg;
    logic              tap_reg, hold_reg, longp_reg;

    logic accept, out_free;
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid || !out_stall;

    ecbj_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // Encoder accumulate
    logic signed [16:0] acc;
    logic [16:0]        acc_mag;
    logic [6:0]         steps_eff;
    assign acc       = 17'(enc_rem_reg) + 17'(encoder_delta_in);
    assign acc_mag   = acc[16] ? 17'(-acc) : acc;
    assign steps_eff = (enc_steps_reg == '0) ? 7'd1 : enc_steps_reg;

    // Axis prep
    axis_prep_t px, py, pcur;
    assign px   = axis_prep(rawx_reg, cx_reg);
    assign py   = axis_prep(rawy_reg, cy_reg);
    assign pcur = (state_reg == S_LX || state_reg == S_AX) ? px : py;

    // Dead zone offset from the axis divide
    logic [15:0] a_q;
    logic [14:0] live;
    assign a_q  = drsp.quot[15:0];
    assign live = (a_q < DEAD_Q) ? 15'd0 : 15'(a_q - DEAD_Q);

    // Axis finish: rescale the live part by reciprocal multiply, clamp
    logic [43:0]        lq_prod;
    logic [15:0]        lq;
    logic [14:0]        lmag;
    logic signed [15:0] axis_val;
    assign lq_prod = {29'd0, live_reg} * {15'd0, LIVE_RECIP};
    assign lq      = lq_prod[43:28];
    assign lmag    = (lq > 16'd32767) ? 15'h7FFF : lq[14:0];
    always_comb
    begin
        if (dead_reg || pcur.span == '0)
            axis_val = '0;
        else if (pcur.neg)
            axis_val = -$signed({1'b0, lmag});
        else
            axis_val = $signed({1'b0, lmag});
    end

    // Encoder quotient and remainder
    logic [16:0]        qmag;
    logic signed [15:0] q_sat;
    logic signed [7:0]  r_s;
    assign qmag = drsp.quot[16:0];
    always_comb
    begin
        if (acc_neg_reg)
            q_sat = (qmag > 17'd32768) ? 16'sh8000 : 16'(-$signed(qmag));
        else
            q_sat = (qmag > 17'd32767) ? 16'sh7FFF : $signed(qmag[15:0]);
        r_s = acc_neg_reg ? 8'(-$signed({1'b0, drsp.rem[6:0]})) : $signed({1'b0, drsp.rem[6:0]});
    end

    // Press timing: microseconds to milliseconds by reciprocal multiply,
    // anything from 2^30 us up is past the held limit
    logic        el_big;
    logic [54:0] ms_prod;
    logic [20:0] ms;
    logic [19:0] held_c;
    logic        longp_c;
    assign el_big  = |elapsed_reg[47:30];
    assign ms_prod = {28'd0, elapsed_reg[29:3]} * {27'd0, MS_RECIP};
    assign ms      = ms_prod[54:34];
    assign held_c  = pressed_reg ? ((el_big || ms[20]) ? HELD_MAX : ms[19:0]) : 20'd0;
    assign longp_c = pressed_reg && !long_done_reg && (held_c >= LONG_MS);

    // Shared smoothing multiplier
    logic signed [16:0] sm_v, sm_s, sm_diff, sm_q;
    logic signed [32:0] sm_prod, sm_p;
    logic signed [15:0] sm_new;
    always_comb
    begin
        if (state_reg == S_SMX)
        begin
            sm_v = 17'(ay_reg);
            sm_s = 17'(sx_reg);
        end
        else
        begin
            sm_v = -17'(ax_reg);
            sm_s = 17'(sy_reg);
        end
    end
    assign sm_diff = sm_v - sm_s;
    assign sm_prod = 33'(sm_diff) * $signed({17'd0, ALPHA_Q});
    assign sm_p    = sm_prod + $signed({17'd0, HALF_Q});
    assign sm_q    = 17'(sm_p >>> 15);
    assign sm_new  = 16'(sm_s + sm_q);

    // Flick detection
    logic [1:0] fl_x, fl_y;
    logic [1:0] rdy_next;
    logic       off_c;
    always_comb
    begin
        rdy_next = flick_rdy_reg;
        fl_x = 2'b00;
        fl_y = 2'b00;
        if (flick_rdy_reg[0] && sx_reg > $signed({1'b0, FLICK_Q[14:0]}))
        begin
            fl_x = 2'b10;
            rdy_next[0] = 1'b0;
        end
        else if (flick_rdy_reg[0] && sx_reg < -$signed({1'b0, FLICK_Q[14:0]}))
        begin
            fl_x = 2'b01;
            rdy_next[0] = 1'b0;
        end
        else if (sx_reg < $signed({1'b0, REARM_Q[14:0]}) && sx_reg > -$signed({1'b0, REARM_Q[14:0]}))
            rdy_next[0] = 1'b1;
        if (flick_rdy_reg[1] && sy_reg > $signed({1'b0, FLICK_Q[14:0]}))
        begin
            fl_y = 2'b10;
            rdy_next[1] = 1'b0;
        end
        else if (flick_rdy_reg[1] && sy_reg < -$signed({1'b0, FLICK_Q[14:0]}))
        begin
            fl_y = 2'b01;
            rdy_next[1] = 1'b0;
        end
        else if (sy_reg < $signed({1'b0, REARM_Q[14:0]}) && sy_reg > -$signed({1'b0, REARM_Q[14:0]}))
            rdy_next[1] = 1'b1;
        off_c = (ax_reg > $signed(HALF_Q)) || (ax_reg < -$signed(HALF_Q))
             || (ay_reg > $signed(HALF_Q)) || (ay_reg < -$signed(HALF_Q));
    end

    // Sequencer: next state and divider launches
    always_comb
    begin
        state_next = state_reg;
        dreq       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    dreq.start = 1'b1;
                    dreq.nbits = 6'd17;
                    dreq.den   = {9'd0, steps_eff};
                    dreq.num   = {acc_mag, 31'd0};
                    state_next = S_ENC;
                end
            end
            S_ENC:
            begin
                if (drsp.done)
                    state_next = S_MS;
            end
            S_MS:
            begin
                if (present_reg)
                begin
                    dreq.start = 1'b1;
                    dreq.nbits = 6'd27;
                    dreq.den   = {4'd0, px.span};
                    dreq.num   = {px.mag, 36'd0};
                    state_next = S_AX;
                end
                else
                    state_next = S_FIN;
            end
            S_AX, S_AY:
            begin
                if (drsp.done)
                    state_next = (state_reg == S_AX) ? S_LX : S_LY;
            end
            S_LX:
            begin
                dreq.start = 1'b1;
                dreq.nbits = 6'd27;
                dreq.den   = {4'd0, py.span};
                dreq.num   = {py.mag, 36'd0};
                state_next = S_AY;
            end
            S_LY:    state_next = S_SMX;
            S_SMX:   state_next = S_SMY;
            S_SMY:   state_next = S_FIN;
            S_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_steps_reg   <= 7'd4;
            cx_reg          <= 12'd2048;
            cy_reg          <= 12'd2048;
            active_reg      <= 1'b0;
            off_cnt_reg     <= '0;
            enc_rem_reg     <= '0;
            btn_was_reg     <= 1'b0;
            long_done_reg   <= 1'b0;
            boot_origin_reg <= 1'b0;
            stick_was_reg   <= 1'b0;
            press_start_reg <= '0;
            sx_reg          <= '0;
            sy_reg          <= '0;
            flick_rdy_reg   <= 2'b11;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ENC_STEPS: enc_steps_reg <= cfg_data[6:0];
                    REG_CENTRE_X:  cx_reg <= cfg_data;
                    REG_CENTRE_Y:  cy_reg <= cfg_data;
                    REG_JOY_EN:
                    begin
                        active_reg  <= cfg_data[0];
                        off_cnt_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (accept)
            begin
                btn_was_reg   <= boot_button || encoder_button;
                stick_was_reg <= stick_button;
                if ((boot_button || encoder_button) && !btn_was_reg)
                begin
                    press_start_reg <= time_us;
                    long_done_reg   <= 1'b0;
                    boot_origin_reg <= boot_button;
                end
            end
            if (state_reg == S_ENC && drsp.done)
                enc_rem_reg <= r_s;
            if (state_reg == S_MS && longp_c)
                long_done_reg <= 1'b1;
            if (state_reg == S_SMX)
                sx_reg <= sm_new;
            if (state_reg == S_SMY)
                sy_reg <= sm_new;
            if (state_reg == S_FIN && out_free && present_reg)
            begin
                flick_rdy_reg <= rdy_next;
                if (off_c)
                begin
                    if (off_cnt_reg >= OFF_LIMIT)
                        active_reg <= 1'b0;
                    if (off_cnt_reg < OFF_CNT_MAX)
                        off_cnt_reg <= off_cnt_reg + 10'd1;
                end
                else
                    off_cnt_reg <= '0;
            end
        end
    end

    // Per-poll payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            acc_neg_reg   <= acc[16];
            pressed_reg   <= boot_button || encoder_button;
            prev_down_reg <= btn_was_reg;
            click_reg     <= !stick_button && stick_was_reg;
            present_reg   <= active_reg;
            rawx_reg      <= raw_x;
            rawy_reg      <= raw_y;
            elapsed_reg   <= ((boot_button || encoder_button) && !btn_was_reg)
                             ? 48'd0 : (time_us - press_start_reg);
            ax_reg        <= '0;
            ay_reg        <= '0;
        end
        if (state_reg == S_ENC && drsp.done)
            q_reg <= q_sat;
        if (state_reg == S_MS)
        begin
            held_reg  <= held_c;
            longp_reg <= longp_c;
            tap_reg   <= !pressed_reg && prev_down_reg && !long_done_reg && !el_big
                         && ms >= TAP_MIN_MS && ms < HOLD_MIN_MS;
            hold_reg  <= !pressed_reg && prev_down_reg && !long_done_reg
                         && (el_big || ms >= HOLD_MIN_MS);
        end
        if ((state_reg == S_AX || state_reg == S_AY) && drsp.done)
        begin
            dead_reg <= a_q < DEAD_Q;
            live_reg <= live;
        end
        if (state_reg == S_LX)
            ax_reg <= axis_val;
        if (state_reg == S_LY)
            ay_reg <= axis_val;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (state_reg == S_FIN && out_free)
            out_valid <= 1'b1;
        else if (!out_stall)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && out_free)
        begin
            detent_steps    <= q_reg;
            button_down     <= pressed_reg;
            held_ms         <= held_reg;
            tap             <= tap_reg;
            hold_release    <= hold_reg;
            long_press      <= longp_reg;
            press_from_boot <= boot_origin_reg;
            stick_click     <= click_reg;
            stick_present   <= present_reg;
            stick_x         <= present_reg ? sx_reg : 16'sd0;
            stick_y         <= present_reg ? sy_reg : 16'sd0;
            flicks          <= present_reg ? {fl_y, fl_x} : 4'd0;
        end
    end

endmodule

// ===== rtl/core/ecbj_checker.sv =====
// Port-level checks for the conditioner, bound to the top level.
// Depends on encoder_button_joystick_conditioner_top.
module ecbj_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        button_down,
    input logic [19:0] held_ms,
    input logic        tap,
    input logic        hold_release,
    input logic        stick_present,
    input logic [15:0] stick_x,
    input logic [15:0] stick_y,
    input logic [3:0]  flicks
);

    // A taken transaction keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken right after a transaction");

    // Inactive stick reports nothing
    a_stick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !stick_present |-> stick_x == 16'd0 && stick_y == 16'd0 && flicks == 4'd0)
        else $error("stick output while not present");

    // Held time only while pressed; release classes exclusive and only on release
    a_held_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !button_down |-> held_ms == 20'd0)
        else $error("held time while released");

    a_release_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (tap || hold_release) |-> !button_down && !(tap && hold_release))
        else $error("bad release classification");

    // Stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind encoder_button_joystick_conditioner_top ecbj_checker u_ecbj_checker (.*);
